// ===== hdl/bdss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdss_pkg
// Shared types, segment codes and the digit-to-segment table for the
// byte to decimal seven-segment decoder.
// ----------------------------------------------------------------------------
package bdss_pkg;

	localparam logic [7:0] SEG_BLANK = 8'h00;
	localparam logic [7:0] SEG_MINUS = 8'h01;

	typedef struct packed {
		logic       neg;
		logic [1:0] hundreds;
		logic [3:0] tens;
		logic [3:0] ones;
	} digits_t;

	typedef struct packed {
		logic [7:0] thousands;
		logic [7:0] hundreds;
		logic [7:0] tens;
		logic [7:0] ones;
	} segs_t;

	function automatic logic [7:0] digit_seg(input logic [3:0] d);
		logic [7:0] s;
		case (d)
			4'd0:    s = 8'h7e;
			4'd1:    s = 8'h30;
			4'd2:    s = 8'h6d;
			4'd3:    s = 8'h79;
			4'd4:    s = 8'h33;
			4'd5:    s = 8'h5b;
			4'd6:    s = 8'h5f;
			4'd7:    s = 8'h70;
			4'd8:    s = 8'h7f;
			4'd9:    s = 8'h7b;
			default: s = SEG_BLANK;
		endcase
		return s;
	endfunction

endpackage

// ===== hdl/bdss_split.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdss_split
// Takes the magnitude of the byte and splits it into decimal digits.
// ----------------------------------------------------------------------------
module bdss_split (
	input  logic                   signed_mode,
	input  logic [7:0]             value,
	output bdss_pkg::digits_t      digits
);

	logic        neg;
	logic [7:0]  mag;
	logic [7:0]  rem_full;
	logic [6:0]  rem;
	logic [1:0]  hund;
	logic [14:0] prod;
	logic [3:0]  tens;
	logic [6:0]  ones_w;

	always_comb begin
		neg = signed_mode & value[7];
		mag = neg ? (~value + 8'd1) : value;
		if (mag >= 8'd200) begin
			hund     = 2'd2;
			rem_full = mag - 8'd200;
		end else if (mag >= 8'd100) begin
			hund     = 2'd1;
			rem_full = mag - 8'd100;
		end else begin
			hund     = 2'd0;
			rem_full = mag;
		end
		rem    = rem_full[6:0];
		// divide by ten: multiply by 205 / 2048, exact below 1029
		prod   = {8'd0, rem} * 15'd205;
		tens   = prod[14:11];
		ones_w = rem - ({3'd0, tens} * 7'd10);

		digits.neg      = neg;
		digits.hundreds = hund;
		digits.tens     = tens;
		digits.ones     = ones_w[3:0];
	end

endmodule

// ===== hdl/bdss_encode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdss_encode
// Maps digits to segment patterns with leading-zero blanking and minus sign.
// ----------------------------------------------------------------------------
module bdss_encode (
	input  bdss_pkg::digits_t digits,
	output bdss_pkg::segs_t   segs
);

	always_comb begin
		segs.ones      = bdss_pkg::digit_seg(digits.ones);
		segs.tens      = bdss_pkg::digit_seg(digits.tens);
		segs.hundreds  = bdss_pkg::digit_seg({2'd0, digits.hundreds});
		segs.thousands = bdss_pkg::SEG_BLANK;
		if (digits.hundreds == 2'd0) begin
			segs.hundreds = bdss_pkg::SEG_BLANK;
			if (digits.tens == 4'd0) begin
				segs.tens = digits.neg ? bdss_pkg::SEG_MINUS : bdss_pkg::SEG_BLANK;
			end else if (digits.neg) begin
				segs.hundreds = bdss_pkg::SEG_MINUS;
			end
		end else if (digits.neg) begin
			segs.thousands = bdss_pkg::SEG_MINUS;
		end
	end

endmodule

// ===== hdl/byte_to_decimal_seven_segment.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_to_decimal_seven_segment
// Converts a byte to four common-cathode seven-segment patterns, unsigned or
// two's complement, with leading-zero blanking and a floating minus sign.
// ----------------------------------------------------------------------------
// Path: input register, then result register; the input register passes its
//   decoded value on once the result register is empty or out_ready is high.
// Throughput: one item per cycle; the result register stalls only on out_ready.
// Reset: arst_n clears both valid bits and signed_mode; payload is not reset.
module byte_to_decimal_seven_segment (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] value,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] seg_ones,
	output logic [7:0] seg_tens,
	output logic [7:0] seg_hundreds,
	output logic [7:0] seg_thousands
);

	logic              signed_mode_q;
	logic              valid_s1;
	logic [7:0]        value_s1;
	logic              mode_s1;
	logic              valid_s2;
	bdss_pkg::segs_t   segs_s2;
	bdss_pkg::digits_t digits;
	bdss_pkg::segs_t   segs;
	logic              adv_s1;

	assign cfg_ready = 1'b1;
	assign adv_s1    = valid_s1 & (~valid_s2 | out_ready);
	assign in_ready  = ~valid_s1 | adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			signed_mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			signed_mode_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			value_s1 <= value;
			mode_s1  <= signed_mode_q;
		end
	end

	bdss_split u_split (
		.signed_mode (mode_s1),
		.value       (value_s1),
		.digits      (digits)
	);

	bdss_encode u_encode (
		.digits (digits),
		.segs   (segs)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (~valid_s2 | out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			segs_s2 <= segs;
		end
	end

	assign out_valid     = valid_s2;
	assign seg_ones      = segs_s2.ones;
	assign seg_tens      = segs_s2.tens;
	assign seg_hundreds  = segs_s2.hundreds;
	assign seg_thousands = segs_s2.thousands;

endmodule

// ===== hdl/bdss_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdss_checker
// Port-level checks for byte_to_decimal_seven_segment, bound to the top level.
// ----------------------------------------------------------------------------
module bdss_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] seg_ones,
	input logic [7:0] seg_tens,
	input logic [7:0] seg_hundreds,
	input logic [7:0] seg_thousands
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(seg_ones) && $stable(seg_tens)
			&& $stable(seg_hundreds) && $stable(seg_thousands))
		else $error("result changed while stalled");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result without input transfer two cycles earlier");

	a_blank_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && seg_tens == bdss_pkg::SEG_BLANK |->
			seg_hundreds == bdss_pkg::SEG_BLANK && seg_thousands == bdss_pkg::SEG_BLANK)
		else $error("digit shown above a blank tens position");

	a_minus_top: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && seg_thousands == bdss_pkg::SEG_MINUS |->
			seg_hundreds != bdss_pkg::SEG_BLANK && seg_hundreds != bdss_pkg::SEG_MINUS)
		else $error("minus in thousands without a hundreds digit");

endmodule

bind byte_to_decimal_seven_segment bdss_checker u_bdss_checker (.*);

// ===== verif/byte_to_decimal_seven_segment_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_to_decimal_seven_segment_test
// Self-checking bench for the byte to decimal seven-segment decoder. Bytes
// are sent in both display modes: first edge values and every minus
// position, then mode changes, a long output stall, and weighted random
// bytes. Random gaps appear on the input and the output. Each result is
// predicted when its input transfer is seen and compared field by field.
// ----------------------------------------------------------------------------
module byte_to_decimal_seven_segment_test;

	localparam bit MODE_UNSIGNED = 1'b0;
	localparam bit MODE_SIGNED   = 1'b1;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int PRINT_LIMIT   = 40;
	localparam logic [79:0] DIGIT_PATTERNS = {
		8'h7b, 8'h7f, 8'h70, 8'h5f, 8'h5b, 8'h33, 8'h79, 8'h6d, 8'h30, 8'h7e
	};

	logic       clk;
	logic       arst_n;
	logic       cfg_valid;
	logic       cfg_ready;
	logic       cfg_data;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] value;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] seg_ones;
	logic [7:0] seg_tens;
	logic [7:0] seg_hundreds;
	logic [7:0] seg_thousands;

	bdss_pkg::segs_t pending_segments[$];
	bit    display_signed = MODE_UNSIGNED;
	bit    tx_idle = 1'b0;
	bit    rx_idle = 1'b0;
	int    holdoff_cycles = 0;
	int    error_count = 0;
	int    sent_count = 0;
	int    negative_count = 0;
	int    checked_count = 0;
	int    mode_writes = 0;
	int    cycle_count = 0;

	byte_to_decimal_seven_segment dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.value        (value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.seg_ones     (seg_ones),
		.seg_tens     (seg_tens),
		.seg_hundreds (seg_hundreds),
		.seg_thousands(seg_thousands)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [7:0] digit_pattern(input int d);
		return DIGIT_PATTERNS[d*8 +: 8];
	endfunction

	function automatic bdss_pkg::segs_t predict_segments(input logic [7:0] raw,
			input bit as_signed);
		bit              neg;
		int              magnitude;
		int              hund_d;
		int              tens_d;
		bdss_pkg::segs_t s;
		neg       = as_signed && raw[7];
		magnitude = neg ? 256 - int'(raw) : int'(raw);
		hund_d    = magnitude / 100;
		tens_d    = (magnitude / 10) % 10;
		s.ones      = digit_pattern(magnitude % 10);
		s.tens      = digit_pattern(tens_d);
		s.hundreds  = digit_pattern(hund_d);
		s.thousands = bdss_pkg::SEG_BLANK;
		if (hund_d == 0) begin
			s.hundreds = bdss_pkg::SEG_BLANK;
			if (tens_d == 0) begin
				s.tens = neg ? bdss_pkg::SEG_MINUS : bdss_pkg::SEG_BLANK;
			end else if (neg) begin
				s.hundreds = bdss_pkg::SEG_MINUS;
			end
		end else if (neg) begin
			s.thousands = bdss_pkg::SEG_MINUS;
		end
		return s;
	endfunction

	function automatic logic [7:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 8'($urandom_range(0, 12));
			1: return 8'($urandom_range(95, 112));
			2: return 8'($urandom_range(195, 212));
			3: return 8'($urandom_range(240, 255));
			4: return 8'($urandom_range(120, 140));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		error_count++;
		if (error_count <= PRINT_LIMIT) begin
			$display("[%0t] MISMATCH: %s", $realtime, msg);
		end
	endtask

	task automatic check_field(input string field, input logic [7:0] got,
			input logic [7:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("%s got 0x%02h expected 0x%02h", field, got, want));
		end
	endtask

	// Inputs stay stable from one rising edge to the next, so a handshake
	// seen at the falling edge is the transfer at the following rising edge.
	always @(negedge clk) begin
		bdss_pkg::segs_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_segments.size() == 0) begin
				report_mismatch("result transfer with no value outstanding");
			end else begin
				want = pending_segments.pop_front();
				check_field("seg_ones", seg_ones, want.ones);
				check_field("seg_tens", seg_tens, want.tens);
				check_field("seg_hundreds", seg_hundreds, want.hundreds);
				check_field("seg_thousands", seg_thousands, want.thousands);
				checked_count++;
			end
		end
	end

	initial begin
		int stall_left;
		stall_left = 0;
		out_ready  = 1'b0;
		forever begin
			@(posedge clk);
			if (holdoff_cycles > 0) begin
				holdoff_cycles--;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (rx_idle && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 19) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding",
				cycle_count, pending_segments.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic send_value(input logic [7:0] v);
		int gap;
		value    <= v;
		in_valid <= 1'b1;
		@(negedge clk);
		while (!in_ready) @(negedge clk);
		pending_segments.push_back(predict_segments(v, display_signed));
		sent_count++;
		if (display_signed && v[7]) negative_count++;
		@(posedge clk);
		if (tx_idle && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 19);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending_segments.size() != 0) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic write_mode(input bit mode);
		drain();
		cfg_data  <= mode;
		cfg_valid <= 1'b1;
		@(negedge clk);
		while (!cfg_ready) @(negedge clk);
		@(posedge clk);
		display_signed = mode;
		mode_writes++;
		cfg_valid <= 1'b0;
	endtask

	task automatic test_unsigned_edges();
		logic [7:0] vals[$] = '{8'd0, 8'd1, 8'd9, 8'd10, 8'd99, 8'd100, 8'd101,
			8'd109, 8'd110, 8'd127, 8'd128, 8'd255};
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		foreach (vals[i]) send_value(vals[i]);
	endtask

	task automatic test_signed_minus_positions();
		logic [7:0] vals[$] = '{8'h00, 8'h01, 8'h7f, 8'h80, 8'hff, 8'hf7, 8'hf6,
			8'hce, 8'h9c, 8'h9b, 8'h94, 8'h81, 8'h64};
		write_mode(MODE_SIGNED);
		foreach (vals[i]) send_value(vals[i]);
	endtask

	task automatic test_mode_switching();
		for (int k = 0; k < 4; k++) begin
			write_mode(k[0] ? MODE_SIGNED : MODE_UNSIGNED);
			send_value(8'h80);
			send_value(8'hff);
			send_value(8'(100 + k));
		end
	endtask

	task automatic test_output_backpressure();
		write_mode(MODE_SIGNED);
		drain();
		holdoff_cycles = 150;
		for (int k = 0; k < 40; k++) send_value(8'($urandom_range(0, 255)));
	endtask

	task automatic run_random_phase(input int count, input bit mode, input bit idle);
		write_mode(mode);
		tx_idle = idle;
		rx_idle = idle;
		repeat (count) send_value(pick_value());
	endtask

	task automatic test_random_values();
		for (int p = 0; p < 8; p++) begin
			run_random_phase(80, p[0] ^ bit'($urandom_range(0, 1)), p != 3);
		end
		run_random_phase(60, MODE_UNSIGNED, 1'b0);
		run_random_phase(60, MODE_SIGNED, 1'b0);
	endtask

	initial begin
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_data  = 1'b0;
		in_valid  = 1'b0;
		value     = 8'h00;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_unsigned_edges();
		test_signed_minus_positions();
		test_mode_switching();
		test_output_backpressure();
		test_random_values();

		drain();
		repeat (8) @(posedge clk);
		$display("Sent %0d bytes (%0d shown negative) over %0d mode writes",
			sent_count, negative_count, mode_writes);
		$display("Checked %0d segment results, %0d mismatches", checked_count, error_count);
		if (error_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
